// ===== rtl/core/text_page_framebuffer_renderer_top_assert.svh =====
// Assertion macros used by the text renderer back end.
`ifndef TEXT_PAGE_FRAMEBUFFER_RENDERER_TOP_ASSERT_SVH
`define TEXT_PAGE_FRAMEBUFFER_RENDERER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TPFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define TPFR_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TPFR_ASSERT(label, prop, msg)
`define TPFR_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/core/tpfr_pkg.sv =====
// Shared types, codes and glyph tables of the text renderer.
package tpfr_pkg;

	localparam int DEF_WIDTH   = 128;
	localparam int DEF_PAGES   = 8;
	localparam int GLYPH_COLS  = 5;
	localparam int DRAW_STEPS  = GLYPH_COLS + 1;
	localparam int WORD_BYTES  = 8;
	localparam int CMD_BYTES   = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h02;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	localparam logic [5:0] QMARK_GLYPH = 6'd8;

	typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_DRAW  = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [2:0] line;
		logic [7:0] column;
		glyph_t     glyph;
	} cmd_t;

	// Upper-case the code and map it to a glyph row; unknown codes map to '?'.
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] up;
		logic [5:0] idx;
		up = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
		unique case (up) inside
			8'h20:          idx = 6'd0;
			8'h21:          idx = 6'd1;
			8'h2E:          idx = 6'd2;
			8'h2F:          idx = 6'd3;
			8'h3A:          idx = 6'd4;
			8'h2D:          idx = 6'd5;
			8'h3E:          idx = 6'd6;
			8'h3C:          idx = 6'd7;
			8'h3F:          idx = QMARK_GLYPH;
			[8'h30:8'h39]:  idx = 6'(up - 8'h30) + 6'd9;
			[8'h41:8'h5A]:  idx = 6'(up - 8'h41) + 6'd19;
			default:        idx = QMARK_GLYPH;
		endcase
		return idx;
	endfunction

	// Glyph columns, leftmost column in element 0.
	function automatic glyph_t glyph_bits(input logic [5:0] idx);
		glyph_t g;
		unique case (idx)
			6'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
			6'd1:  g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
			6'd2:  g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
			6'd3:  g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
			6'd4:  g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
			6'd5:  g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
			6'd6:  g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h00};
			6'd7:  g = {8'h08, 8'h14, 8'h22, 8'h41, 8'h00};
			6'd8:  g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
			6'd9:  g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			6'd10: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			6'd11: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			6'd12: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			6'd13: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			6'd14: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			6'd15: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			6'd16: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			6'd17: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			6'd18: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			6'd19: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
			6'd20: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
			6'd21: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
			6'd22: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
			6'd23: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			6'd24: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
			6'd25: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
			6'd26: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
			6'd27: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
			6'd28: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
			6'd29: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
			6'd30: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			6'd31: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
			6'd32: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
			6'd33: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			6'd34: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
			6'd35: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
			6'd36: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			6'd37: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			6'd38: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
			6'd39: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
			6'd40: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
			6'd41: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
			6'd42: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
			6'd43: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
			6'd44: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
			default: g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/core/tpfr_front.sv =====
// Front end: accept items, track the text cursor and emit commands for the back end.
module tpfr_front import tpfr_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH,
	parameter int PAGES = DEF_PAGES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hold,
	input  logic       queue_full,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] op,
	input  logic       first,
	input  logic [3:0] line,
	input  logic [7:0] start_column,
	input  logic [7:0] ch,
	input  logic [2:0] page,
	output logic       push_valid,
	output cmd_t       push_cmd
);

	logic [7:0] cursor_column_q;
	logic [2:0] cursor_line_q;
	logic       string_active_q;

	logic       accept;
	logic       new_ok;
	logic       active_eff;
	logic       fits;
	logic [2:0] line_eff;
	logic [7:0] col_eff;
	logic [8:0] col_end;

	assign item_ready = !hold && !queue_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		new_ok = (line < 4'(PAGES)) && (start_column < 8'(WIDTH));
		if (first) begin
			active_eff = new_ok;
			line_eff   = line[2:0];
			col_eff    = start_column;
		end else begin
			active_eff = string_active_q;
			line_eff   = cursor_line_q;
			col_eff    = cursor_column_q;
		end
		col_end = {1'b0, col_eff} + 9'(GLYPH_COLS);
		fits    = col_end < 9'(WIDTH);

		push_cmd.kind   = CMD_CLEAR;
		push_cmd.line   = line_eff;
		push_cmd.column = col_eff;
		push_cmd.glyph  = glyph_bits(glyph_index(ch));
		push_valid      = 1'b0;
		unique case (op)
			OP_CLEAR: begin
				push_valid = accept;
			end
			OP_DRAW: begin
				push_cmd.kind = CMD_DRAW;
				push_valid    = accept && active_eff && fits;
			end
			OP_FLUSH: begin
				push_cmd.kind = CMD_FLUSH;
				push_cmd.line = page;
				push_valid    = accept && ({1'b0, page} < 4'(PAGES));
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	// Glyph plus spacer always fit together, so the cursor advances by six.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= '0;
			cursor_line_q   <= '0;
			string_active_q <= 1'b0;
		end else if (accept && op == OP_DRAW) begin
			if (active_eff && fits) begin
				cursor_line_q   <= line_eff;
				cursor_column_q <= col_end[7:0] + 8'd1;
				string_active_q <= 1'b1;
			end else begin
				string_active_q <= 1'b0;
				if (first && new_ok) begin
					cursor_line_q   <= line[2:0];
					cursor_column_q <= start_column;
				end
			end
		end
	end

endmodule

// ===== rtl/core/tpfr_queue.sv =====
// Short command queue between the front and back ends.
module tpfr_queue import tpfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic full,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/tpfr_back.sv =====
// Back end: framebuffer memory, clear sweep, glyph writes and page flush output.
`include "text_page_framebuffer_renderer_top_assert.svh"
module tpfr_back import tpfr_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH,
	parameter int PAGES = DEF_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        init_busy,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [63:0] word,
	output logic [3:0]  byte_count,
	output logic        last
);

	localparam int DEPTH = WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_CLEAR   = 6'b000010,
		ST_DRAW    = 6'b000100,
		ST_FL_CMD  = 6'b001000,
		ST_FL_RD   = 6'b010000,
		ST_FL_PUSH = 6'b100000
	} state_t;

	state_t     state_q;
	logic       init_q;
	logic [2:0] line_q;
	logic [7:0] col_q;
	logic [2:0] idx_q;
	glyph_t     glyph_q;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic          mem_we;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_addr;

	logic       rd_pend_s1;
	logic [2:0] rd_slot_s1;
	logic [WORD_BYTES-1:0][7:0] asm_q;
	logic [2:0] end_slot_q;
	logic       last_word_q;

	logic        out_valid_q;
	logic        kind_q;
	logic        last_q;
	logic [63:0] word_q;
	logic [3:0]  count_q;

	logic slot_free;
	logic col_end;
	logic line_end;
	logic word_end;
	logic rd_issue;
	logic draw_done;
	logic out_load;

	assign slot_free = !out_valid_q || result_ready;
	assign col_end   = (col_q == 8'(WIDTH - 1));
	assign line_end  = (line_q == 3'(PAGES - 1));
	assign word_end  = (idx_q == 3'(WORD_BYTES - 1)) || col_end;
	assign rd_issue  = (state_q == ST_FL_RD);
	assign draw_done = (state_q == ST_DRAW) && (idx_q == 3'(DRAW_STEPS - 1));
	assign out_load  = slot_free && ((state_q == ST_FL_CMD) ||
		((state_q == ST_FL_PUSH) && !rd_pend_s1));
	assign mem_addr  = AW'(int'(line_q) * WIDTH + int'(col_q));
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_DRAW);
	assign mem_wdata = (state_q == ST_DRAW) ? glyph_q[0] : 8'h00;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = init_q;

	// Single-port framebuffer with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else begin
			rd_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			init_q      <= 1'b1;
			line_q      <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						line_q <= (q_cmd.kind == CMD_CLEAR) ? 3'd0 : q_cmd.line;
						col_q  <= (q_cmd.kind == CMD_DRAW) ? q_cmd.column : 8'd0;
						idx_q  <= '0;
						unique case (q_cmd.kind)
							CMD_CLEAR: state_q <= ST_CLEAR;
							CMD_DRAW:  state_q <= ST_DRAW;
							CMD_FLUSH: state_q <= ST_FL_CMD;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLEAR: begin
					if (col_end) begin
						col_q <= '0;
						if (line_end) begin
							state_q <= ST_IDLE;
							init_q  <= 1'b0;
						end else begin
							line_q <= line_q + 3'd1;
						end
					end else begin
						col_q <= col_q + 8'd1;
					end
				end
				ST_DRAW: begin
					col_q <= col_q + 8'd1;
					idx_q <= idx_q + 3'd1;
					if (draw_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_CMD: begin
					if (slot_free) begin
						state_q <= ST_FL_RD;
					end
				end
				ST_FL_RD: begin
					col_q <= col_q + 8'd1;
					idx_q <= idx_q + 3'd1;
					if (word_end) begin
						state_q <= ST_FL_PUSH;
					end
				end
				ST_FL_PUSH: begin
					// Wait for the last byte of the word to land, then hand it on.
					if (!rd_pend_s1 && slot_free) begin
						idx_q   <= '0;
						state_q <= last_word_q ? ST_IDLE : ST_FL_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					glyph_q <= q_cmd.glyph;
					asm_q   <= '0;
				end
			end
			ST_DRAW: begin
				glyph_q <= {glyph_q[1:GLYPH_COLS-1], 8'h00};
			end
			ST_FL_CMD: begin
				if (slot_free) begin
					kind_q  <= KIND_CMD;
					word_q  <= 64'({CMD_COL_HIGH, CMD_COL_LOW, CMD_PAGE_BASE | {5'b0, line_q}});
					count_q <= 4'(CMD_BYTES);
					last_q  <= 1'b0;
				end
			end
			ST_FL_RD: begin
				if (word_end) begin
					end_slot_q  <= idx_q;
					last_word_q <= col_end;
				end
			end
			ST_FL_PUSH: begin
				if (!rd_pend_s1 && slot_free) begin
					kind_q  <= KIND_DATA;
					word_q  <= asm_q;
					count_q <= {1'b0, end_slot_q} + 4'd1;
					last_q  <= last_word_q;
					asm_q   <= '0;
				end
			end
			default: begin
			end
		endcase
		if (rd_pend_s1) begin
			asm_q[rd_slot_s1] <= rd_q;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign word         = word_q;
	assign byte_count   = count_q;
	assign last         = last_q;

	`TPFR_ASSERT(a_rd_follows_issue, rd_pend_s1 |-> $past(state_q == ST_FL_RD), "stray read data")
	`TPFR_ASSERT(a_init_is_sweep, init_q |-> (state_q == ST_CLEAR), "sweep left the clear state")
	`TPFR_ASSERT(a_draw_six_writes, draw_done |=> (state_q == ST_IDLE), "draw ran past six writes")
	`TPFR_NEVER(a_no_cmd_in_init, init_q && q_valid, "command queued during initial sweep")

endmodule

// ===== rtl/core/text_page_framebuffer_renderer_top.sv =====
// Top level of the page-mode text renderer: front end, command queue and back end.
//
// Renders 5x7 text into a PAGES x WIDTH page-mode framebuffer (one byte per column per
// page, bit n is pixel row n) and streams pages out for a display link. The front end
// takes one item per cycle while the queue has room: it tracks the cursor, upper-cases and
// looks up each character and drops items that do nothing (rejected strings, characters
// that do not fit, flushes of missing pages, the unused op code), then queues real work in
// a two-entry queue. The back end owns a single-port framebuffer memory, and its one memory
// port sets the cost of each operation. The back end first takes a command from the queue;
// a draw then writes five glyph columns and a blank spacer, one write each, a clear
// sweeps the whole store, and a flush sends the command word and then, per data word,
// reads its bytes in turn, collects them and hands the word on, stalling while
// result_ready is held low.
// Results come from an output register, so the queue keeps filling while a result waits.
// After reset the back end clears the framebuffer; item_ready stays low until that sweep
// is done.
module text_page_framebuffer_renderer_top import tpfr_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH,
	parameter int PAGES = DEF_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  op,
	input  logic        first,
	input  logic [3:0]  line,
	input  logic [7:0]  start_column,
	input  logic [7:0]  ch,
	input  logic [2:0]  page,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [63:0] word,
	output logic [3:0]  byte_count,
	output logic        last
);

	// Commands move from the front end into the queue on every push transfer.
	logic push_valid;
	cmd_t push_cmd;
	logic queue_full;

	// The back end pops one command at a time once it is idle.
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	// Hold the input side while the post-reset clear sweep runs.
	logic init_busy;

	tpfr_front #(
		.WIDTH (WIDTH),
		.PAGES (PAGES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (init_busy),
		.queue_full   (queue_full),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.first        (first),
		.line         (line),
		.start_column (start_column),
		.ch           (ch),
		.page         (page),
		.push_valid   (push_valid),
		.push_cmd     (push_cmd)
	);

	tpfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd),
		.pop        (q_pop)
	);

	tpfr_back #(
		.WIDTH (WIDTH),
		.PAGES (PAGES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.init_busy    (init_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.word         (word),
		.byte_count   (byte_count),
		.last         (last)
	);

endmodule
